@@ rtl/stream_group_reverser_macros.svh @@
// Assertion macros for the group reverser. Each expects clk and rst_n in scope.
`ifndef STREAM_GROUP_REVERSER_MACROS_SVH
`define STREAM_GROUP_REVERSER_MACROS_SVH

`ifndef ASSERT_OFF
`define SRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SRG_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SRG_ASSERT(lbl, prop, msg)
`define SRG_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/srev_pkg.sv @@
`timescale 1ns / 1ps
package srev_pkg;

  localparam int unsigned MAX_GROUP_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned GS_W          = 5;
  localparam int unsigned CFG_AW        = 3;
  localparam int unsigned CFG_DW        = 32;

  // register index, taken from paddr[2]
  localparam logic REG_GROUP_SIZE = 1'b0;

  localparam logic [GS_W-1:0] GROUP_SIZE_RST = GS_W'(1);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              run_end;
    logic              seq_end;
  } beat_t;

  typedef struct packed {
    logic busy;
    logic load;
  } stat_t;

endpackage

@@ rtl/srev_mem.sv @@
`timescale 1ns / 1ps
module srev_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/srev_ctrl.sv @@
`timescale 1ns / 1ps
module srev_ctrl #(
  parameter int unsigned MAX_GROUP = 16,
  parameter int unsigned AW        = 4,
  parameter int unsigned CW        = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [srev_pkg::GS_W-1:0]     group_size,
  input  logic                          cfg_clear,
  input  logic                          in_valid,
  input  logic [srev_pkg::DATA_W-1:0]   in_data,
  input  logic                          in_last,
  output logic                          in_ready,
  input  logic                          out_free,
  output srev_pkg::beat_t               beat,
  output srev_pkg::stat_t               stat,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [srev_pkg::DATA_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [srev_pkg::DATA_W-1:0]   mem_rdata
);

  import srev_pkg::*;

  localparam int unsigned KW = (CW > GS_W) ? CW : GS_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_LD   = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          rev_r, rev_nxt;
  logic          last_r, last_nxt;

  logic [CW-1:0] k;
  logic [CW-1:0] n;
  logic          pass;
  logic          accept;
  logic [AW-1:0] addr_step;

  // clamp oversized groups to the buffer depth
  always_comb begin
    if (KW'(group_size) > KW'(MAX_GROUP)) begin
      k = CW'(MAX_GROUP);
    end else begin
      k = CW'(group_size);
    end
  end

  assign pass      = (k <= CW'(1));
  assign n         = CW'(fill_r) + CW'(1);
  assign in_ready  = (st_r == ST_IDLE) && (out_free || !pass);
  assign accept    = in_valid && in_ready;
  assign addr_step = rev_r ? (addr_r - AW'(1)) : (addr_r + AW'(1));

  assign mem_waddr = fill_r;
  assign mem_wdata = in_data;

  always_comb begin
    st_nxt    = st_r;
    fill_nxt  = fill_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    rev_nxt   = rev_r;
    last_nxt  = last_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = addr_r;
    stat.busy = (st_r != ST_IDLE);
    stat.load = 1'b0;
    beat      = '{data: in_data, run_end: 1'b1, seq_end: in_last};
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (pass) begin
            stat.load = 1'b1;
            fill_nxt  = '0;
          end else begin
            mem_we = 1'b1;
            if ((n == k) || in_last) begin
              // group complete or sequence over: drain from the buffer
              fill_nxt = '0;
              rev_nxt  = (n == k);
              addr_nxt = (n == k) ? AW'(fill_r) : '0;
              left_nxt = n;
              last_nxt = in_last;
              st_nxt   = ST_RD;
            end else begin
              fill_nxt = AW'(n);
            end
          end
        end
      end
      ST_RD: begin
        mem_re   = 1'b1;
        addr_nxt = addr_step;
        st_nxt   = ST_LD;
      end
      ST_LD: begin
        beat = '{data: mem_rdata, run_end: (left_r == CW'(1)),
                 seq_end: (left_r == CW'(1)) && last_r};
        if (out_free) begin
          stat.load = 1'b1;
          left_nxt  = left_r - CW'(1);
          if (left_r == CW'(1)) begin
            st_nxt = ST_IDLE;
          end else begin
            // fetch the next word while this one moves out
            mem_re   = 1'b1;
            addr_nxt = addr_step;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (cfg_clear) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      fill_r <= '0;
      left_r <= '0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rev_r  <= rev_nxt;
    last_r <= last_nxt;
  end

endmodule

@@ rtl/stream_group_reverser.sv @@
`timescale 1ns / 1ps
// Group reverser: elements arrive one per beat on in_*, and each group of group_size
// elements leaves on out_* in reverse order; a short group closed by in_tlast leaves in
// arrival order, and group_size 0 or 1 passes every beat straight through. out_tlast
// closes the beats caused by one input beat, out_tuser marks the end of the sequence.
// Rate: a beat that only fills the buffer leaves in_tready high; pass-through runs at
// one beat per cycle while out_tready is high. The beat that closes a group of n
// elements is followed by a drain (state ST_RD issues the first read of the buffer
// memory, then ST_LD moves each word out and fetches the next), which stalls while
// out_tready is low and during which in_tready stays low. Writing group_size discards
// any partial group. No clearing pass is run after reset.
module stream_group_reverser #(
  parameter int unsigned MAX_GROUP = srev_pkg::MAX_GROUP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [srev_pkg::DATA_W-1:0]   in_tdata,   // item_data
  input  logic                          in_tlast,   // item_last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [srev_pkg::DATA_W-1:0]   out_tdata,  // out_data
  output logic                          out_tlast,  // out_run_end
  output logic                          out_tuser,  // out_seq_end
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [srev_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [srev_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [srev_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  import srev_pkg::*;

`include "stream_group_reverser_macros.svh"

  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);

  logic [GS_W-1:0]   gs_r, gs_nxt;
  logic              cfg_wr;
  logic              out_valid_r, out_valid_nxt;
  beat_t             out_beat_r, out_beat_nxt;
  logic              out_free;
  beat_t             beat;
  stat_t             stat;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_GROUP_SIZE);
  assign gs_nxt     = cfg_wr ? cfg_pwdata[GS_W-1:0] : gs_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_GROUP_SIZE) ? CFG_DW'(gs_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r <= GROUP_SIZE_RST;
    end else begin
      gs_r <= gs_nxt;
    end
  end

  srev_ctrl #(
    .MAX_GROUP (MAX_GROUP),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .group_size (gs_r),
    .cfg_clear  (cfg_wr),
    .in_valid   (in_tvalid),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .in_ready   (in_tready),
    .out_free   (out_free),
    .beat       (beat),
    .stat       (stat),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  srev_mem #(
    .DEPTH (MAX_GROUP),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (stat.load) begin
      out_valid_nxt = 1'b1;
      out_beat_nxt  = beat;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_beat_r.data;
  assign out_tlast  = out_beat_r.run_end;
  assign out_tuser  = out_beat_r.seq_end;

  `SRG_NEVER(a_no_accept_while_draining, stat.busy && in_tready, "input taken during drain")
  `SRG_NEVER(a_no_overwrite, stat.load && out_valid_r && !out_tready, "pending beat overwritten")
  `SRG_ASSERT(a_seq_end_closes_run, out_valid_r && out_tuser |-> out_tlast, "seq end without run end")

endmodule
